@@ src/binary_prefix_trie_defines.svh @@
// assertion macros for the binary prefix trie
// used by the top level, no other dependencies
`ifndef BINARY_PREFIX_TRIE_DEFINES_SVH
`define BINARY_PREFIX_TRIE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bpt_pkg.sv @@
// shared types and codes for the binary prefix trie
// no dependencies
`default_nettype none

package bpt_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_NEXT   = 2'd2;

  localparam int unsigned LEN_BITS = 6;

  // write enables of the node store, one per array
  typedef struct packed {
    logic lch;
    logic rch;
    logic full;
    logic parent;
    logic tag;
  } wr_en_t;

endpackage

`default_nettype wire

@@ src/bpt_node_mem.sv @@
// node store of the trie: child links, parent link, full mark and tag
// depends on bpt_pkg
`default_nettype none

module bpt_node_mem #(
  parameter int unsigned NODE_COUNT = 1024,
  parameter int unsigned TAG_BITS   = 16,
  localparam int unsigned NW        = $clog2(NODE_COUNT)
) (
  input  wire logic                clk_i,
  input  wire logic                rd_en_i,
  input  wire logic [NW-1:0]       rd_addr_i,
  input  wire bpt_pkg::wr_en_t     wr_en_i,
  input  wire logic [NW-1:0]       wr_addr_i,
  input  wire logic [NW-1:0]       wr_lch_i,
  input  wire logic [NW-1:0]       wr_rch_i,
  input  wire logic                wr_full_i,
  input  wire logic [NW-1:0]       wr_parent_i,
  input  wire logic [TAG_BITS-1:0] wr_tag_i,
  output logic [NW-1:0]            rd_lch_o,
  output logic [NW-1:0]            rd_rch_o,
  output logic                     rd_full_o,
  output logic [NW-1:0]            rd_parent_o,
  output logic [TAG_BITS-1:0]      rd_tag_o
);

  logic [NW-1:0]       lch_mem    [NODE_COUNT];
  logic [NW-1:0]       rch_mem    [NODE_COUNT];
  logic                full_mem   [NODE_COUNT];
  logic [NW-1:0]       parent_mem [NODE_COUNT];
  logic [TAG_BITS-1:0] tag_mem    [NODE_COUNT];

  always_ff @(posedge clk_i) begin
    if (wr_en_i.lch) lch_mem[wr_addr_i] <= wr_lch_i;
    if (rd_en_i) rd_lch_o <= lch_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i.rch) rch_mem[wr_addr_i] <= wr_rch_i;
    if (rd_en_i) rd_rch_o <= rch_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i.full) full_mem[wr_addr_i] <= wr_full_i;
    if (rd_en_i) rd_full_o <= full_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i.parent) parent_mem[wr_addr_i] <= wr_parent_i;
    if (rd_en_i) rd_parent_o <= parent_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i.tag) tag_mem[wr_addr_i] <= wr_tag_i;
    if (rd_en_i) rd_tag_o <= tag_mem[rd_addr_i];
  end

endmodule

`default_nettype wire

@@ src/binary_prefix_trie.sv @@
// sequencing: insert and find read and evaluate one node per level, from the root
//   down len levels; next reads and checks each node visited or climbed
// throughput: one word at a time; every level costs one node store read on
//   the single read port plus an evaluate state
// reset: clears the sequencer, the pool count (root only), the root links and full mark;
//   the node store is not swept, each node is cleared when it is allocated
`default_nettype none

module binary_prefix_trie #(
  parameter int unsigned NODE_COUNT = 1024,
  parameter int unsigned ADDR_BITS  = 32,
  parameter int unsigned TAG_BITS   = 16,
  localparam int unsigned NW        = $clog2(NODE_COUNT)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   op_i,
  input  wire logic [ADDR_BITS-1:0]         prefix_addr_i,
  input  wire logic [bpt_pkg::LEN_BITS-1:0] prefix_len_i,
  input  wire logic [TAG_BITS-1:0]          entry_tag_i,
  input  wire logic [NW-1:0]                start_node_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [NW-1:0]                     node_index_o,
  output logic                              hit_o,
  output logic                              node_full_o,
  output logic [TAG_BITS-1:0]               tag_out_o,
  output logic                              newly_set_o,
  output logic                              pool_exhausted_o
);

`include "binary_prefix_trie_defines.svh"

  localparam int unsigned NU_W = NW + 1;
  localparam int unsigned LW   = $clog2(ADDR_BITS + 1);
  localparam int unsigned CW   = (LW > bpt_pkg::LEN_BITS) ? LW : bpt_pkg::LEN_BITS;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a word
  localparam logic [2:0] S_RD   = 3'd1;  // read (or clear) node cur_q
  localparam logic [2:0] S_WALK = 3'd2;  // insert/find: evaluate one level
  localparam logic [2:0] S_DOWN = 3'd3;  // next: check node, step down
  localparam logic [2:0] S_UP   = 3'd4;  // next: climbed to a parent
  localparam logic [2:0] S_ZERO = 3'd5;  // all-zero result

  logic [2:0]           state_q, state_d;
  logic [2:0]           ret_q, ret_d;      // state after the read
  logic [1:0]           op_q, op_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;    // prefix, shifted one bit a level
  logic [LW-1:0]        len_q, len_d;
  logic [LW-1:0]        lvl_q, lvl_d;
  logic [TAG_BITS-1:0]  tag_q, tag_d;
  logic [NW-1:0]        cur_q, cur_d;
  logic [NW-1:0]        par_q, par_d;      // parent on insert, child on climb
  logic                 fresh_q, fresh_d;  // cur_q was just allocated
  logic                 first_q, first_d;  // next: still at start node
  logic                 rd_root_q, rd_zero_q;
  logic [NU_W-1:0]      nodes_used_q, nodes_used_d;
  logic [NW-1:0]        root_lch_q, root_lch_d;
  logic [NW-1:0]        root_rch_q, root_rch_d;
  logic                 root_full_q, root_full_d;

  // node store
  logic                 rd_en;
  bpt_pkg::wr_en_t      wr_en;
  logic [NW-1:0]        wr_lch, wr_rch, wr_parent;
  logic                 wr_full;
  logic [NW-1:0]        mem_lch, mem_rch, mem_parent;
  logic                 mem_full;
  logic [TAG_BITS-1:0]  mem_tag;

  // effective node data: a fresh node reads as empty, the root from flops
  logic [NW-1:0]        lch_eff, rch_eff, nxt;
  logic                 full_eff;

  // result slot
  logic                 out_free, res_load;
  logic [NW-1:0]        res_node;
  logic                 res_hit, res_full, res_new, res_exh;
  logic [TAG_BITS-1:0]  res_tag;
  logic [CW-1:0]        len_ext;

  bpt_node_mem #(
    .NODE_COUNT (NODE_COUNT),
    .TAG_BITS   (TAG_BITS)
  ) u_mem (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_i   (cur_q),
    .wr_en_i     (wr_en),
    .wr_addr_i   (cur_q),
    .wr_lch_i    (wr_lch),
    .wr_rch_i    (wr_rch),
    .wr_full_i   (wr_full),
    .wr_parent_i (wr_parent),
    .wr_tag_i    (tag_q),
    .rd_lch_o    (mem_lch),
    .rd_rch_o    (mem_rch),
    .rd_full_o   (mem_full),
    .rd_parent_o (mem_parent),
    .rd_tag_o    (mem_tag)
  );

  always_comb begin
    lch_eff  = rd_zero_q ? '0 : (rd_root_q ? root_lch_q : mem_lch);
    rch_eff  = rd_zero_q ? '0 : (rd_root_q ? root_rch_q : mem_rch);
    full_eff = rd_zero_q ? 1'b0 : (rd_root_q ? root_full_q : mem_full);
    nxt      = addr_q[ADDR_BITS-1] ? rch_eff : lch_eff;
  end

  assign out_free   = !out_valid_o || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign len_ext    = CW'(prefix_len_i);

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    op_d         = op_q;
    addr_d       = addr_q;
    len_d        = len_q;
    lvl_d        = lvl_q;
    tag_d        = tag_q;
    cur_d        = cur_q;
    par_d        = par_q;
    fresh_d      = fresh_q;
    first_d      = first_q;
    nodes_used_d = nodes_used_q;
    root_lch_d   = root_lch_q;
    root_rch_d   = root_rch_q;
    root_full_d  = root_full_q;
    rd_en        = 1'b0;
    wr_en        = '0;
    wr_lch       = '0;
    wr_rch       = '0;
    wr_full      = 1'b0;
    wr_parent    = par_q;
    res_load     = 1'b0;
    res_node     = '0;
    res_hit      = 1'b0;
    res_full     = 1'b0;
    res_tag      = '0;
    res_new      = 1'b0;
    res_exh      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_i;
          addr_d  = prefix_addr_i;
          tag_d   = entry_tag_i;
          lvl_d   = '0;
          fresh_d = 1'b0;
          first_d = 1'b1;
          // overlong prefixes saturate to the address width
          if (len_ext > CW'(ADDR_BITS)) len_d = LW'(ADDR_BITS);
          else len_d = LW'(len_ext);
          if (op_i == bpt_pkg::OP_INSERT || op_i == bpt_pkg::OP_FIND) begin
            cur_d   = '0;
            ret_d   = S_WALK;
            state_d = S_RD;
          end else if (op_i == bpt_pkg::OP_NEXT &&
                       NU_W'(start_node_i) < nodes_used_q) begin
            cur_d   = start_node_i;
            ret_d   = S_DOWN;
            state_d = S_RD;
          end else begin
            state_d = S_ZERO;
          end
        end
      end

      S_RD: begin
        rd_en = 1'b1;
        // a node allocated one level up gets its child links and full mark cleared and its parent link set here
        if (fresh_q) begin
          wr_en.lch    = 1'b1;
          wr_en.rch    = 1'b1;
          wr_en.full   = 1'b1;
          wr_en.parent = 1'b1;
        end
        state_d = ret_q;
      end

      S_WALK: begin
        if (lvl_q == len_q) begin
          if (out_free) begin
            res_load = 1'b1;
            res_node = cur_q;
            res_hit  = 1'b1;
            if (op_q == bpt_pkg::OP_INSERT) begin
              res_full = 1'b1;
              res_new  = !full_eff;
              res_tag  = full_eff ? mem_tag : tag_q;
              if (!full_eff) begin
                wr_en.full = 1'b1;
                wr_en.tag  = 1'b1;
                wr_full    = 1'b1;
                if (cur_q == '0) root_full_d = 1'b1;
              end
            end else begin
              res_full = full_eff;
              res_tag  = full_eff ? mem_tag : '0;
            end
            state_d = S_IDLE;
          end
        end else if (nxt != '0) begin
          cur_d   = nxt;
          lvl_d   = lvl_q + 1'b1;
          addr_d  = addr_q << 1;
          state_d = S_RD;
        end else if (op_q == bpt_pkg::OP_FIND) begin
          // absent child: miss, all fields zero
          if (out_free) begin
            res_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else if (nodes_used_q == NU_W'(NODE_COUNT)) begin
          if (out_free) begin
            res_load = 1'b1;
            res_node = cur_q;
            res_exh  = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          // allocate the next pool node and link it under cur_q
          if (addr_q[ADDR_BITS-1]) begin
            wr_en.rch = 1'b1;
            wr_rch    = nodes_used_q[NW-1:0];
            if (cur_q == '0) root_rch_d = nodes_used_q[NW-1:0];
          end else begin
            wr_en.lch = 1'b1;
            wr_lch    = nodes_used_q[NW-1:0];
            if (cur_q == '0) root_lch_d = nodes_used_q[NW-1:0];
          end
          par_d        = cur_q;
          cur_d        = nodes_used_q[NW-1:0];
          nodes_used_d = nodes_used_q + 1'b1;
          fresh_d      = 1'b1;
          lvl_d        = lvl_q + 1'b1;
          addr_d       = addr_q << 1;
          state_d      = S_RD;
        end
      end

      S_DOWN: begin
        if (!first_q && full_eff) begin
          if (out_free) begin
            res_load = 1'b1;
            res_node = cur_q;
            res_hit  = 1'b1;
            res_full = 1'b1;
            res_tag  = mem_tag;
            state_d  = S_IDLE;
          end
        end else if (lch_eff != '0) begin
          cur_d   = lch_eff;
          first_d = 1'b0;
          state_d = S_RD;
        end else if (rch_eff != '0) begin
          cur_d   = rch_eff;
          first_d = 1'b0;
          state_d = S_RD;
        end else if (cur_q == '0) begin
          if (out_free) begin
            res_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          // leaf: climb to the parent, remember where we came from
          par_d   = cur_q;
          cur_d   = mem_parent;
          ret_d   = S_UP;
          state_d = S_RD;
        end
      end

      S_UP: begin
        if (lch_eff == par_q && rch_eff != '0) begin
          cur_d   = rch_eff;
          first_d = 1'b0;
          ret_d   = S_DOWN;
          state_d = S_RD;
        end else if (cur_q == '0) begin
          if (out_free) begin
            res_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          par_d   = cur_q;
          cur_d   = mem_parent;
          state_d = S_RD;
        end
      end

      S_ZERO: begin
        if (out_free) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fresh_q      <= 1'b0;
      nodes_used_q <= NU_W'(1);
      root_lch_q   <= '0;
      root_rch_q   <= '0;
      root_full_q  <= 1'b0;
      out_valid_o  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fresh_q      <= fresh_d;
      nodes_used_q <= nodes_used_d;
      root_lch_q   <= root_lch_d;
      root_rch_q   <= root_rch_d;
      root_full_q  <= root_full_d;
      if (res_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ret_q   <= ret_d;
    op_q    <= op_d;
    addr_q  <= addr_d;
    len_q   <= len_d;
    lvl_q   <= lvl_d;
    tag_q   <= tag_d;
    cur_q   <= cur_d;
    par_q   <= par_d;
    first_q <= first_d;
    if (rd_en) begin
      rd_root_q <= (cur_q == '0);
      rd_zero_q <= fresh_q;
    end
    if (res_load) begin
      node_index_o     <= res_node;
      hit_o            <= res_hit;
      node_full_o      <= res_full;
      tag_out_o        <= res_tag;
      newly_set_o      <= res_new;
      pool_exhausted_o <= res_exh;
    end
  end

  `BPT_ASSERT_NOW(a_pool_bound, 1'b1, nodes_used_q <= NU_W'(NODE_COUNT), "pool count overflow")
  `BPT_ASSERT_NOW(a_no_overwrite, res_load, !out_valid_o || out_ready_i, "result overwritten")
  `BPT_ASSERT_NOW(a_fresh_insert, fresh_q && state_q != S_IDLE, op_q == bpt_pkg::OP_INSERT, "fresh outside insert")
  `BPT_ASSERT_NOW(a_fresh_not_root, fresh_q && state_q != S_IDLE, cur_q != '0, "root marked fresh")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// testbench for binary_prefix_trie: random and directed insert, find and next words
// depends on bpt_pkg and the trie rtl; predicts every result with its own trie copy
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODES = 1024;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int unsigned IDLE_LIMIT = 50000;
  localparam int unsigned HOLD_CYCLES = 400;

  // one input word
  typedef struct {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [5:0]  len;
    logic [15:0] tag;
    logic [9:0]  start;
  } route_word_t;

  // one result word
  typedef struct {
    logic [9:0]  node;
    logic        hit;
    logic        full;
    logic [15:0] tag;
    logic        fresh;
    logic        exhausted;
  } trie_answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [31:0] prefix_addr_i = '0;
  logic [5:0]  prefix_len_i = '0;
  logic [15:0] entry_tag_i = '0;
  logic [9:0]  start_node_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [9:0]  node_index_o;
  logic        hit_o;
  logic        node_full_o;
  logic [15:0] tag_out_o;
  logic        newly_set_o;
  logic        pool_exhausted_o;

  binary_prefix_trie dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .prefix_addr_i, .prefix_len_i,
    .entry_tag_i, .start_node_i, .out_valid_o, .out_ready_i, .node_index_o, .hit_o,
    .node_full_o, .tag_out_o, .newly_set_o, .pool_exhausted_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow copy of the trie
  int unsigned  left_of [NODES];
  int unsigned  right_of [NODES];
  int unsigned  parent_of [NODES];
  bit           is_full [NODES];
  logic [15:0]  tag_of [NODES];
  int unsigned  pool_used = 1;

  route_word_t  route_q [$];
  trie_answer_t answer_q [$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  results_seen = 0;
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;
  logic [31:0]  bases [12];

  // apply one word to the shadow trie and return what the block should answer
  function automatic trie_answer_t trie_apply(route_word_t w);
    trie_answer_t r;
    int unsigned  cur, nxt, up, len, steps;
    bit           go_right, climbed;
    r = '{default: '0};
    cur = 0;
    len = (w.len > 32) ? 32 : w.len;
    case (w.op)
      bpt_pkg::OP_INSERT: begin
        for (int i = 0; i < len; i++) begin
          go_right = w.addr[31-i];
          nxt = go_right ? right_of[cur] : left_of[cur];
          if (nxt == 0) begin
            // pool full: stop where the walk stands
            if (pool_used >= NODES) begin
              r.node = 10'(cur);
              r.exhausted = 1'b1;
              return r;
            end
            nxt = pool_used++;
            left_of[nxt] = 0;
            right_of[nxt] = 0;
            is_full[nxt] = 1'b0;
            parent_of[nxt] = cur;
            if (go_right) right_of[cur] = nxt;
            else left_of[cur] = nxt;
          end
          cur = nxt;
        end
        r.node = 10'(cur);
        r.hit = 1'b1;
        r.full = 1'b1;
        r.fresh = !is_full[cur];
        if (!is_full[cur]) begin
          is_full[cur] = 1'b1;
          tag_of[cur] = w.tag;
        end
        r.tag = tag_of[cur];
      end
      bpt_pkg::OP_FIND: begin
        for (int i = 0; i < len; i++) begin
          nxt = w.addr[31-i] ? right_of[cur] : left_of[cur];
          if (nxt == 0) return r;
          cur = nxt;
        end
        r.node = 10'(cur);
        r.hit = 1'b1;
        r.full = is_full[cur];
        r.tag = is_full[cur] ? tag_of[cur] : '0;
      end
      bpt_pkg::OP_NEXT: begin
        if (w.start >= pool_used) return r;
        cur = w.start;
        for (steps = 0; steps < NODES; steps++) begin
          // preorder successor: left child, right child, else climb
          if (left_of[cur] != 0) cur = left_of[cur];
          else if (right_of[cur] != 0) cur = right_of[cur];
          else begin
            climbed = 1'b0;
            while (cur != 0 && !climbed) begin
              up = parent_of[cur];
              if (left_of[up] == cur && right_of[up] != 0) begin
                cur = right_of[up];
                climbed = 1'b1;
              end else begin
                cur = up;
              end
            end
          end
          if (cur == 0) break;
          if (is_full[cur]) begin
            r.node = 10'(cur);
            r.hit = 1'b1;
            r.full = 1'b1;
            r.tag = tag_of[cur];
            return r;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // random word: mostly prefixes near a few shared bases so paths overlap, some noise
  function automatic route_word_t random_route();
    route_word_t w;
    int unsigned pick;
    pick = $urandom_range(99);
    w.tag = 16'($urandom);
    w.addr = bases[$urandom_range(11)] ^ ($urandom & 32'h0000_0fff);
    w.len = 6'($urandom_range(32));
    if ($urandom_range(3) == 0) w.len = 6'($urandom_range(12));
    w.start = 10'($urandom_range(pool_used + 4 > NODES - 1 ? NODES - 1 : pool_used + 4));
    if (pick < 40) w.op = bpt_pkg::OP_INSERT;
    else if (pick < 70) w.op = bpt_pkg::OP_FIND;
    else if (pick < 90) w.op = bpt_pkg::OP_NEXT;
    else begin
      // noise: any op, any address, overlong lengths, any start
      w.op = 2'($urandom_range(3));
      w.addr = $urandom;
      w.len = 6'($urandom_range(63));
      w.start = 10'($urandom_range(NODES - 1));
    end
    return w;
  endfunction

  // driver: holds the word until it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (route_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        op_i          <= route_q[0].op;
        prefix_addr_i <= route_q[0].addr;
        prefix_len_i  <= route_q[0].len;
        entry_tag_i   <= route_q[0].tag;
        start_node_i  <= route_q[0].start;
        void'(route_q.pop_front());
        in_valid_i    <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off once results flow
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && results_seen >= 40) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on accepted input, check on accepted output
  always @(posedge clk_i) begin
    trie_answer_t want;
    route_word_t  w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        w = '{op: op_i, addr: prefix_addr_i, len: prefix_len_i, tag: entry_tag_i,
              start: start_node_i};
        answer_q.push_back(trie_apply(w));
      end
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (answer_q.size() == 0) begin
          $error("result word with nothing pending");
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          if (node_index_o !== want.node) begin
            $error("node_index: expected %0d, got %0d", want.node, node_index_o);
            mismatches++;
          end
          if (hit_o !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit_o);
            mismatches++;
          end
          if (node_full_o !== want.full) begin
            $error("node_full: expected %0d, got %0d", want.full, node_full_o);
            mismatches++;
          end
          if (tag_out_o !== want.tag) begin
            $error("tag_out: expected %h, got %h", want.tag, tag_out_o);
            mismatches++;
          end
          if (newly_set_o !== want.fresh) begin
            $error("newly_set: expected %0d, got %0d", want.fresh, newly_set_o);
            mismatches++;
          end
          if (pool_exhausted_o !== want.exhausted) begin
            $error("pool_exhausted: expected %0d, got %0d", want.exhausted,
                   pool_exhausted_o);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus phases: no idling, sender idle, receiver stalling, both
  initial begin
    int unsigned idle_set [4];
    int unsigned stall_set [4];
    idle_set = '{0, 83, 0, 22};
    stall_set = '{0, 0, 83, 22};
    foreach (bases[i]) bases[i] = $urandom;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words: root, extremes, repeats, overlong, misses, unused op
    route_q.push_back('{bpt_pkg::OP_FIND,   32'h0,         6'd0,  16'h0,    10'd0});
    route_q.push_back('{bpt_pkg::OP_NEXT,   32'h0,         6'd0,  16'h0,    10'd0});
    route_q.push_back('{bpt_pkg::OP_INSERT, 32'h0,         6'd0,  16'hffff, 10'd0});
    route_q.push_back('{bpt_pkg::OP_INSERT, 32'h0,         6'd0,  16'h1234, 10'd0});
    route_q.push_back('{bpt_pkg::OP_INSERT, 32'hffff_ffff, 6'd32, 16'h0000, 10'h3ff});
    route_q.push_back('{bpt_pkg::OP_INSERT, 32'h0,         6'd32, 16'hffff, 10'd0});
    route_q.push_back('{bpt_pkg::OP_INSERT, 32'h8000_0000, 6'd63, 16'ha5a5, 10'd0});
    route_q.push_back('{bpt_pkg::OP_INSERT, 32'hffff_ffff, 6'd40, 16'h5a5a, 10'd0});
    route_q.push_back('{bpt_pkg::OP_FIND,   32'hffff_ffff, 6'd32, 16'h0,    10'd0});
    route_q.push_back('{bpt_pkg::OP_FIND,   32'hffff_ffff, 6'd16, 16'h0,    10'd0});
    route_q.push_back('{bpt_pkg::OP_FIND,   32'h1234_5678, 6'd8,  16'h0,    10'd0});
    route_q.push_back('{bpt_pkg::OP_FIND,   32'h8000_0000, 6'd33, 16'h0,    10'd0});
    route_q.push_back('{bpt_pkg::OP_NEXT,   32'h0,         6'd0,  16'h0,    10'd0});
    route_q.push_back('{bpt_pkg::OP_NEXT,   32'h0,         6'd0,  16'h0,    10'd1});
    route_q.push_back('{bpt_pkg::OP_NEXT,   32'h0,         6'd0,  16'h0,    10'd32});
    route_q.push_back('{bpt_pkg::OP_NEXT,   32'h0,         6'd0,  16'h0,    10'd64});
    route_q.push_back('{bpt_pkg::OP_NEXT,   32'h0,         6'd0,  16'h0,    10'h3ff});
    route_q.push_back('{OP_NOP,             32'hffff_ffff, 6'd63, 16'hffff, 10'h3ff});
    route_q.push_back('{bpt_pkg::OP_FIND,   32'h0,         6'd32, 16'h0,    10'd0});

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_set[p];
      recv_stall_pct = stall_set[p];
      for (int n = 0; n < 270; n++) route_q.push_back(random_route());
      // pool_used moves as words are taken, so refill waits for the queue to drain
      while (route_q.size() > 0 || in_valid_i || answer_q.size() > 0) @(posedge clk_i);
    end

    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && answer_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
